### hw/rtl/cc20_pkg.sv
// Shared types, constants and block-function helpers for the ChaCha20 stream unit.
package cc20_pkg;

  typedef logic [31:0]       word_t;
  typedef logic [15:0][31:0] state_t;

  // 10 double rounds, each round split into two half quarter-round steps
  localparam int unsigned DblRounds = 10;
  localparam int unsigned HalfSteps = 4 * DblRounds;
  localparam int unsigned StepW     = $clog2(HalfSteps);

  localparam word_t SIGMA [4] = '{32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574};

  typedef enum logic [2:0] {
    CFG_KEY0     = 3'd0,
    CFG_KEY1     = 3'd1,
    CFG_KEY2     = 3'd2,
    CFG_KEY3     = 3'd3,
    CFG_NONCE_LO = 3'd4,
    CFG_NONCE_HI = 3'd5,
    CFG_INIT_CTR = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    GEN_IDLE,
    GEN_RUN,
    GEN_ADD,
    GEN_DONE
  } gen_state_e;

  typedef struct packed {
    logic [255:0] key;
    logic [95:0]  nonce;
    word_t        init_ctr;
  } cfg_t;

  // one keystream block with the counter it was made from
  typedef struct packed {
    state_t ks;
    word_t  ctr;
  } blk_t;

  // generator restart request from the top level
  typedef struct packed {
    logic  restart;
    logic  use_init;
    word_t ctr;
  } restart_t;

  // status of the byte side
  typedef struct packed {
    logic  in_msg;
    logic  last_acc;
    word_t act_ctr;
  } back_stat_t;

  function automatic state_t init_state(cfg_t cfg, word_t ctr);
    state_t s;
    for (int i = 0; i < 4; i++) begin
      s[i] = SIGMA[i];
    end
    for (int k = 0; k < 8; k++) begin
      s[4 + k] = cfg.key[32*k +: 32];
    end
    s[12] = ctr;
    s[13] = cfg.nonce[31:0];
    s[14] = cfg.nonce[63:32];
    s[15] = cfg.nonce[95:64];
    return s;
  endfunction

  // first half: rotations 16 / 12, second half: 8 / 7; returns {d, c, b, a}
  function automatic logic [127:0] qr_half(word_t a, word_t b, word_t c, word_t d,
                                           logic second);
    word_t a1;
    word_t b1;
    word_t c1;
    word_t d1;
    a1 = a + b;
    d1 = d ^ a1;
    d1 = second ? {d1[23:0], d1[31:24]} : {d1[15:0], d1[31:16]};
    c1 = c + d1;
    b1 = b ^ c1;
    b1 = second ? {b1[24:0], b1[31:25]} : {b1[19:0], b1[31:20]};
    return {d1, c1, b1, a1};
  endfunction

endpackage

### hw/rtl/cc20_core.sv
// Keystream generator: iterative ChaCha20 block function, runs ahead of the byte side.
module cc20_core import cc20_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  restart_t rst_req_i,
  output logic     blk_valid_o,
  input  logic     blk_ready_i,
  output blk_t     blk_o
);

  gen_state_e       state_q, state_d;
  state_t           x_q, x_d;
  word_t            blk_ctr_q, blk_ctr_d;
  word_t            gen_ctr_q, gen_ctr_d;
  logic             use_init_q, use_init_d;
  logic [StepW-1:0] step_q, step_d;

  state_t y;
  state_t z;
  state_t xn;
  state_t init_w;
  word_t  start_ctr;
  logic   second;
  logic   diag;

  assign second    = step_q[0];
  assign diag      = step_q[1];
  assign start_ctr = use_init_q ? cfg_i.init_ctr : gen_ctr_q;
  assign init_w    = init_state(cfg_i, blk_ctr_q);

  // diagonal rounds: rotate row r left by r so diagonals line up as columns
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 4; j++) begin
        y[4*r + j] = diag ? x_q[4*r + ((j + r) % 4)] : x_q[4*r + j];
      end
    end
    for (int j = 0; j < 4; j++) begin
      {z[12 + j], z[8 + j], z[4 + j], z[j]} = qr_half(y[j], y[4 + j], y[8 + j], y[12 + j],
                                                      second);
    end
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 4; j++) begin
        if (diag) begin
          xn[4*r + ((j + r) % 4)] = z[4*r + j];
        end else begin
          xn[4*r + j] = z[4*r + j];
        end
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    blk_ctr_d   = blk_ctr_q;
    gen_ctr_d   = gen_ctr_q;
    use_init_d  = use_init_q;
    step_d      = step_q;
    blk_valid_o = 1'b0;
    unique case (state_q)
      GEN_IDLE: begin
        x_d        = init_state(cfg_i, start_ctr);
        blk_ctr_d  = start_ctr;
        gen_ctr_d  = start_ctr + 32'd1;
        use_init_d = 1'b0;
        step_d     = '0;
        state_d    = GEN_RUN;
      end
      GEN_RUN: begin
        x_d    = xn;
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(HalfSteps - 1)) begin
          state_d = GEN_ADD;
        end
      end
      GEN_ADD: begin
        for (int i = 0; i < 16; i++) begin
          x_d[i] = x_q[i] + init_w[i];
        end
        state_d = GEN_DONE;
      end
      GEN_DONE: begin
        blk_valid_o = 1'b1;
        if (blk_ready_i) begin
          state_d = GEN_IDLE;
        end
      end
      default: state_d = GEN_IDLE;
    endcase
    // restart aborts any block in flight
    if (rst_req_i.restart) begin
      state_d    = GEN_IDLE;
      gen_ctr_d  = rst_req_i.ctr;
      use_init_d = rst_req_i.use_init;
    end
  end

  assign blk_o.ks  = x_q;
  assign blk_o.ctr = blk_ctr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= GEN_IDLE;
      gen_ctr_q  <= '0;
      use_init_q <= 1'b1;
      step_q     <= '0;
    end else begin
      state_q    <= state_d;
      gen_ctr_q  <= gen_ctr_d;
      use_init_q <= use_init_d;
      step_q     <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    blk_ctr_q <= blk_ctr_d;
  end

endmodule

### hw/rtl/cc20_blkq.sv
// One-entry keystream block queue between generator and byte side, with flush.
module cc20_blkq import cc20_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic clear_i,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  blk_t push_data_i,
  input  logic pop_i,
  output logic valid_o,
  output blk_t data_o
);

  logic valid_q, valid_d;
  blk_t data_q;
  logic push;

  assign push_ready_o = !valid_q || pop_i;
  assign push         = push_valid_i && push_ready_o && !clear_i;
  assign valid_o      = valid_q;
  assign data_o       = data_q;

  always_comb begin
    valid_d = valid_q;
    if (clear_i) begin
      valid_d = 1'b0;
    end else if (push) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      data_q <= push_data_i;
    end
  end

endmodule

### hw/rtl/cc20_xor.sv
// Byte side: tracks position in the current block and XORs each byte with keystream.
module cc20_xor import cc20_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,
  output logic       m_axis_tlast,
  input  logic       q_valid_i,
  input  blk_t       q_data_i,
  output logic       q_pop_o,
  output back_stat_t stat_o
);

  logic [5:0] pos_q, pos_d;
  logic       in_msg_q, in_msg_d;
  state_t     act_blk_q;
  word_t      act_ctr_q;
  logic       m_valid_q, m_valid_d;
  logic [7:0] m_data_q;
  logic       m_last_q;

  logic       out_free;
  logic       need_blk;
  logic       acc;
  logic [7:0] ks_byte;

  // pos is 0 at every block boundary and whenever a message is about to start
  assign need_blk      = (pos_q == 6'd0);
  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = out_free && (!need_blk || q_valid_i);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign q_pop_o       = acc && need_blk;
  assign ks_byte       = need_blk ? q_data_i.ks[0][7:0]
                                  : act_blk_q[pos_q[5:2]][{pos_q[1:0], 3'b000} +: 8];

  always_comb begin
    pos_d     = pos_q;
    in_msg_d  = in_msg_q;
    m_valid_d = m_valid_q;
    if (acc) begin
      pos_d     = s_axis_tlast ? 6'd0 : pos_q + 6'd1;
      in_msg_d  = !s_axis_tlast;
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      in_msg_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      in_msg_q  <= in_msg_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      m_data_q <= s_axis_tdata ^ ks_byte;
      m_last_q <= s_axis_tlast;
    end
    if (q_pop_o) begin
      act_blk_q <= q_data_i.ks;
      act_ctr_q <= q_data_i.ctr;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tlast    = m_last_q;
  assign stat_o.in_msg   = in_msg_q;
  assign stat_o.last_acc = acc && s_axis_tlast;
  assign stat_o.act_ctr  = act_ctr_q;

endmodule

### hw/rtl/chacha20_stream_cipher_unit.sv
// ChaCha20 stream cipher top level: config registers, generator, block queue, byte side.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata[7:0] data_byte, tlast last_byte
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata[7:0] out_byte, tlast out_last
//  cfg       in   cfg_valid_i/cfg_ready_o       cfg_index_i register, cfg_data_i value
//
// Steady state moves one beat per cycle unless the output or a missing block stalls it;
// the generator makes a 64-byte block (load, 40 half-round steps, one final add, hand-off)
// and works ahead: one block can wait in the queue and one more in the generator.
// The first beat of a message, and a beat that opens a block right after a config write,
// stalls for its block, since a last beat or a config write restarts the generator.
// Reset clears control state; the generator starts on the initial counter right after it.
// Output is one register deep: a beat is taken only when that register is empty or
// draining, so a low m_axis_tready with a result waiting holds s_axis_tready low.
module chacha20_stream_cipher_unit import cc20_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  cfg_t       cfg_q, cfg_d;
  logic       cfg_hit;
  restart_t   rst_req;
  back_stat_t stat;

  logic gen_valid;
  logic gen_ready;
  blk_t gen_blk;
  logic q_valid;
  blk_t q_data;
  logic q_pop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d   = cfg_q;
    cfg_hit = 1'b0;
    if (cfg_valid_i) begin
      cfg_hit = 1'b1;
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_KEY0:     cfg_d.key[63:0]    = cfg_data_i;
        CFG_KEY1:     cfg_d.key[127:64]  = cfg_data_i;
        CFG_KEY2:     cfg_d.key[191:128] = cfg_data_i;
        CFG_KEY3:     cfg_d.key[255:192] = cfg_data_i;
        CFG_NONCE_LO: cfg_d.nonce[63:0]  = cfg_data_i;
        CFG_NONCE_HI: cfg_d.nonce[95:64] = cfg_data_i[31:0];
        CFG_INIT_CTR: cfg_d.init_ctr     = cfg_data_i[31:0];
        default:      cfg_hit            = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // blocks made ahead are stale after a message end or a config change
  assign rst_req.restart  = cfg_hit || stat.last_acc;
  assign rst_req.use_init = stat.last_acc || !stat.in_msg;
  assign rst_req.ctr      = stat.act_ctr + 32'd1;

  cc20_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .rst_req_i   (rst_req),
    .blk_valid_o (gen_valid),
    .blk_ready_i (gen_ready),
    .blk_o       (gen_blk)
  );

  cc20_blkq u_blkq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (rst_req.restart),
    .push_valid_i (gen_valid),
    .push_ready_o (gen_ready),
    .push_data_i  (gen_blk),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .data_o       (q_data)
  );

  cc20_xor u_xor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .q_valid_i     (q_valid),
    .q_data_i      (q_data),
    .q_pop_o       (q_pop),
    .stat_o        (stat)
  );

endmodule
